### rtl/core/aba2f2f_pkg.sv
// Shared constants and types for the track-2 F2F encoder.
`timescale 1ns / 1ps

package aba2f2f_pkg;

    localparam int MAX_PAD     = 24;
    localparam int PAD_W       = 5;
    localparam int NIB_W       = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [PAD_W-1:0] PAD_RESET   = 5'd5;
    localparam logic [PAD_W-1:0] PAD_LIMIT   = PAD_W'(MAX_PAD);
    localparam logic [7:0]       ASCII_BASE  = 8'd48;
    localparam logic [7:0]       NIBBLE_MAX  = 8'd15;
    localparam logic [PAD_W-1:0] PARITY_SLOT = PAD_W'(NIB_W);

    // Operation codes carried on the input tuser.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified request: what the back has to serialize.
    typedef struct packed {
        logic             bad;
        logic [PAD_W-1:0] lead;
        logic [NIB_W-1:0] nibble;
        logic [PAD_W-1:0] trail;
    } t_cmd;

endpackage

### rtl/core/aba2f2f_front.sv
// Front end: accepts requests, tracks message state and the LRC, builds commands.
`timescale 1ns / 1ps

module aba2f2f_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [aba2f2f_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                                 s_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [aba2f2f_pkg::PAD_W-1:0]        i_cfg_wdata,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output aba2f2f_pkg::t_cmd                    o_cmd
);
    import aba2f2f_pkg::*;

    logic             r_started;
    logic [NIB_W-1:0] r_lrc;
    logic [PAD_W-1:0] r_pad;

    logic             n_started;
    logic [NIB_W-1:0] n_lrc;
    logic [PAD_W-1:0] pad_sat;
    logic             char_ok;

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && s_axis_tready;
    assign pad_sat       = (r_pad > PAD_LIMIT) ? PAD_LIMIT : r_pad;
    assign char_ok       = s_axis_tdata inside {[ASCII_BASE:ASCII_BASE + NIBBLE_MAX]};

    always_comb begin
        o_cmd     = '0;
        n_started = r_started;
        n_lrc     = r_lrc;
        if (s_axis_tuser == OP_END) begin
            o_cmd.lead   = r_started ? '0 : pad_sat;
            o_cmd.nibble = r_lrc;
            o_cmd.trail  = pad_sat;
            n_started    = 1'b0;
            n_lrc        = '0;
        end else if (!char_ok) begin
            // A bad character leaves all message state alone.
            o_cmd.bad = 1'b1;
        end else begin
            o_cmd.lead   = r_started ? '0 : pad_sat;
            o_cmd.nibble = NIB_W'(s_axis_tdata - ASCII_BASE);
            n_started    = 1'b1;
            n_lrc        = r_lrc ^ NIB_W'(s_axis_tdata - ASCII_BASE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_lrc     <= '0;
            r_pad     <= PAD_RESET;
        end else begin
            if (o_push) begin
                r_started <= n_started;
                r_lrc     <= n_lrc;
            end
            if (i_cfg_we) begin
                r_pad <= i_cfg_wdata;
            end
        end
    end

endmodule

### rtl/core/aba2f2f_cmd_queue.sv
// Small command queue that decouples the front from the serializer.
`timescale 1ns / 1ps

module aba2f2f_cmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  aba2f2f_pkg::t_cmd  i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output aba2f2f_pkg::t_cmd  o_cmd,
    input  logic               i_pop
);
    import aba2f2f_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/aba2f2f_back.sv
// Back end: serializes commands into stripe bits with F2F ramp directions, bad ones into an error result.
`timescale 1ns / 1ps

module aba2f2f_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    input  aba2f2f_pkg::t_cmd                    i_cmd,
    output logic                                 o_pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [aba2f2f_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import aba2f2f_pkg::*;

    typedef enum logic [2:0] {
        PH_INIT,
        PH_BAD,
        PH_LEAD,
        PH_DATA,
        PH_TRAIL
    } t_phase;

    t_phase           r_phase;
    logic [PAD_W-1:0] r_cnt;
    logic             r_flux;
    logic             r_vld;
    logic             r_bit;
    logic             r_first;
    logic             r_second;
    logic             r_bad;
    logic             r_last;

    t_phase           eff_phase;
    logic [PAD_W-1:0] eff_cnt;
    t_phase           n_phase;
    logic [PAD_W-1:0] n_cnt;
    logic [PAD_W-1:0] cnt_inc;
    logic             emit;
    logic             bit_val;
    logic             is_bad;
    logic             is_final;

    assign emit    = i_cmd_valid && (!r_vld || m_axis_tready);
    assign o_pop   = emit && is_final;
    assign cnt_inc = eff_cnt + PAD_W'(1);

    // The head command is worked on in place; a fresh command picks its first phase here.
    always_comb begin
        eff_phase = r_phase;
        eff_cnt   = r_cnt;
        if (r_phase == PH_INIT) begin
            eff_cnt = '0;
            if (i_cmd.bad) begin
                eff_phase = PH_BAD;
            end else if (i_cmd.lead != '0) begin
                eff_phase = PH_LEAD;
            end else begin
                eff_phase = PH_DATA;
            end
        end
    end

    always_comb begin
        bit_val  = 1'b0;
        is_bad   = 1'b0;
        is_final = 1'b0;
        n_phase  = eff_phase;
        n_cnt    = cnt_inc;
        case (eff_phase)
            PH_LEAD: begin
                if (cnt_inc == i_cmd.lead) begin
                    n_phase = PH_DATA;
                    n_cnt   = '0;
                end
            end
            PH_DATA: begin
                if (eff_cnt == PARITY_SLOT) begin
                    // Odd parity over the four data bits.
                    bit_val = ~^i_cmd.nibble;
                    n_cnt   = '0;
                    if (i_cmd.trail == '0) begin
                        is_final = 1'b1;
                    end else begin
                        n_phase = PH_TRAIL;
                    end
                end else begin
                    bit_val = i_cmd.nibble[eff_cnt[1:0]];
                end
            end
            PH_TRAIL: begin
                if (cnt_inc == i_cmd.trail) begin
                    is_final = 1'b1;
                end
            end
            default: begin
                is_bad   = 1'b1;
                is_final = 1'b1;
            end
        endcase
        if (is_final) begin
            n_phase = PH_INIT;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INIT;
            r_cnt   <= '0;
            r_flux  <= 1'b1;
            r_vld   <= 1'b0;
        end else begin
            if (emit) begin
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_vld    <= 1'b1;
                r_bad    <= is_bad;
                r_last   <= is_final;
                r_bit    <= bit_val;
                r_first  <= is_bad ? 1'b0 : r_flux;
                r_second <= is_bad ? 1'b0 : (r_flux ^ bit_val);
                if (!is_bad) begin
                    r_flux <= ~(r_flux ^ bit_val);
                end
            end else if (m_axis_tready) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 3){1'b0}}, r_second, r_first, r_bit};
    assign m_axis_tuser  = r_bad;
    assign m_axis_tlast  = r_last;

endmodule

### rtl/core/aba_track2_f2f_encoder_core.sv
// Top level of the track-2 stripe encoder with LRC and F2F ramp directions.
// A request is held in the command queue, then its first result is registered at the output.
// The serializer sets the rate: one result per cycle while commands wait and the output
// is not stalled. A character gives four data bits and a parity bit (plus the leading
// pad on the first of a message), an end request the LRC, its parity and the trailing
// pad (plus the leading pad if no character came first), a bad character a single error result.
// Reset (synchronous, active low) empties the queue, clears message state and LRC,
// sets the ramp to rising and the pad count to five.
`timescale 1ns / 1ps

module aba_track2_f2f_encoder_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] char_code
    input  logic [aba2f2f_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  logic                                 s_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [aba2f2f_pkg::PAD_W-1:0]        i_cfg_wdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] bit_value, [1] first_half_dir, [2] second_half_dir, [7:3] zero
    output logic [aba2f2f_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] bad_char
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import aba2f2f_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    aba2f2f_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    aba2f2f_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    aba2f2f_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### rtl/core/aba2f2f_checker.sv
// Port-level checks for the encoder core, bound to the top level.
`timescale 1ns / 1ps

module aba2f2f_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [aba2f2f_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                                 m_axis_tuser,
    input logic                                 m_axis_tlast
);
    import aba2f2f_pkg::*;

    // Nothing is offered in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // An error result is alone and carries no stripe bit.
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("bad character result malformed");

    // F2F: the ramp flips mid-cell exactly for a one.
    a_midcell_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata[2] == (m_axis_tdata[1] ^ m_axis_tdata[0])))
        else $error("second half direction does not match bit value");

endmodule

bind aba_track2_f2f_encoder_core aba2f2f_checker u_aba2f2f_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
